@@ src/pbu_pkg.sv @@
// Shared types and constants for the pixel blend unit.
// Holds the request and result structs, operation codes and register indexes.
package pbu_pkg;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] top_blue;
    logic [7:0] top_green;
    logic [7:0] top_red;
    logic [7:0] base_blue;
    logic [7:0] base_green;
    logic [7:0] base_red;
  } req_t;

  typedef struct packed {
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
  } result_t;

  localparam logic [2:0] OP_MULTIPLY = 3'd0;
  localparam logic [2:0] OP_SCREEN   = 3'd1;
  localparam logic [2:0] OP_OVERLAY  = 3'd2;
  localparam logic [2:0] OP_SUBTRACT = 3'd3;
  localparam logic [2:0] OP_SCALE    = 3'd4;
  localparam logic [2:0] OP_ADD      = 3'd5;

  localparam logic [2:0] REG_BLUE_OFFSET  = 3'd0;
  localparam logic [2:0] REG_GREEN_OFFSET = 3'd1;
  localparam logic [2:0] REG_RED_OFFSET   = 3'd2;
  localparam logic [2:0] REG_BLUE_GAIN    = 3'd3;
  localparam logic [2:0] REG_GREEN_GAIN   = 3'd4;
  localparam logic [2:0] REG_RED_GAIN     = 3'd5;
  localparam logic [2:0] REG_GAIN_ENABLE  = 3'd6;

  localparam logic [15:0] GAIN_RESET = 16'd256;

  typedef enum logic [2:0] {
    KIND_DIRECT = 3'd0,
    KIND_ROUND  = 3'd1,
    KIND_INV    = 3'd2,
    KIND_OVL_HI = 3'd3,
    KIND_SCALE  = 3'd4
  } kind_t;

endpackage

@@ src/pbu_channel.sv @@
// One color channel of the pixel blend unit: a product stage and a finish stage.
// Depends on pbu_pkg for operation codes and the finish-kind type.
module pbu_channel (
  input  logic              clk,
  input  logic [2:0]        op,
  input  logic [7:0]        a,
  input  logic [7:0]        b,
  input  logic [15:0]       gain,
  input  logic              gain_en,
  input  logic signed [8:0] offset,
  output logic [7:0]        res
);
  import pbu_pkg::*;

  logic        inv_next;
  logic [7:0]  x_op;
  logic [7:0]  y_op;
  logic [9:0]  sum_next;
  logic [7:0]  direct_next;
  kind_t       kind_next;

  logic [15:0] prod;
  logic [23:0] scaled;
  logic        dbl;
  logic [7:0]  direct;
  kind_t       kind;

  logic [16:0] p_ext;
  logic [16:0] t_val;
  logic [16:0] s_val;
  logic [8:0]  quot;
  logic [7:0]  res_next;

  always_comb begin
    inv_next = (op == OP_SCREEN) || ((op == OP_OVERLAY) && b[7]);
    x_op = inv_next ? ~a : a;
    y_op = inv_next ? ~b : b;
    sum_next = {2'b00, a} + {offset[8], offset};
    direct_next = a;
    kind_next = KIND_DIRECT;
    case (op)
      OP_MULTIPLY: begin
        kind_next = KIND_ROUND;
      end
      OP_SCREEN: begin
        kind_next = KIND_INV;
      end
      OP_OVERLAY: begin
        kind_next = b[7] ? KIND_OVL_HI : KIND_ROUND;
      end
      OP_SUBTRACT: begin
        direct_next = (b >= a) ? (b - a) : 8'd0;
      end
      OP_SCALE: begin
        if (gain_en) begin
          kind_next = KIND_SCALE;
        end
      end
      OP_ADD: begin
        if (sum_next[9]) begin
          direct_next = 8'd0;
        end else if (sum_next[8]) begin
          direct_next = 8'd255;
        end else begin
          direct_next = sum_next[7:0];
        end
      end
      default: begin
        direct_next = a;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod   <= x_op * y_op;
    scaled <= a * gain;
    dbl    <= (op == OP_OVERLAY);
    direct <= direct_next;
    kind   <= kind_next;
  end

  // Rounded division by 255: floor((p + 127) / 255) through a shift-add identity.
  always_comb begin
    p_ext = dbl ? {prod, 1'b0} : {1'b0, prod};
    t_val = p_ext + 17'd127;
    s_val = t_val + {8'd0, t_val[16:8]} + 17'd1;
    quot  = s_val[16:8];
    case (kind)
      KIND_DIRECT: res_next = direct;
      KIND_ROUND:  res_next = quot[7:0];
      KIND_INV:    res_next = 8'd255 - quot[7:0];
      KIND_OVL_HI: res_next = (quot >= 9'd255) ? 8'd0 : (8'd255 - quot[7:0]);
      KIND_SCALE:  res_next = (scaled[23:16] != 8'd0) ? 8'd255 : scaled[15:8];
      default:     res_next = direct;
    endcase
  end

  always_ff @(posedge clk) begin
    res <= res_next;
  end

endmodule

@@ src/pixel_blend_unit.sv @@
// Pixel blend unit top level: request register, configuration registers and
// three channel datapaths. Depends on pbu_pkg and pbu_channel.
// done and result pass the request register, product and finish stages.
// Throughput: one request per cycle; busy is high only while rst is high.
// The receiver cannot stall; each result is shown for exactly one cycle.
// Reset clears the pipeline valid bits and restores the register defaults.
module pixel_blend_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  pbu_pkg::req_t  req,
  output logic           done,
  output pbu_pkg::result_t result,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [2:0]     cfg_index,
  input  logic [15:0]    cfg_data
);
  import pbu_pkg::*;

  logic              in_valid;
  logic              mid_valid;
  req_t              in_req;
  logic signed [8:0] blue_offset;
  logic signed [8:0] green_offset;
  logic signed [8:0] red_offset;
  logic [15:0]       blue_gain;
  logic [15:0]       green_gain;
  logic [15:0]       red_gain;
  logic [2:0]        gain_enable;

  assign busy = rst;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      mid_valid <= 1'b0;
      done      <= 1'b0;
    end else begin
      in_valid  <= start;
      mid_valid <= in_valid;
      done      <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_req <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blue_offset  <= 9'sd0;
      green_offset <= 9'sd0;
      red_offset   <= 9'sd0;
      blue_gain    <= GAIN_RESET;
      green_gain   <= GAIN_RESET;
      red_gain     <= GAIN_RESET;
      gain_enable  <= 3'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BLUE_OFFSET:  blue_offset  <= cfg_data[8:0];
        REG_GREEN_OFFSET: green_offset <= cfg_data[8:0];
        REG_RED_OFFSET:   red_offset   <= cfg_data[8:0];
        REG_BLUE_GAIN:    blue_gain    <= cfg_data;
        REG_GREEN_GAIN:   green_gain   <= cfg_data;
        REG_RED_GAIN:     red_gain     <= cfg_data;
        REG_GAIN_ENABLE:  gain_enable  <= cfg_data[2:0];
        default: begin
        end
      endcase
    end
  end

  pbu_channel u_blue (
    .clk     (clk),
    .op      (in_req.op),
    .a       (in_req.top_blue),
    .b       (in_req.base_blue),
    .gain    (blue_gain),
    .gain_en (gain_enable[0]),
    .offset  (blue_offset),
    .res     (result.out_blue)
  );

  pbu_channel u_green (
    .clk     (clk),
    .op      (in_req.op),
    .a       (in_req.top_green),
    .b       (in_req.base_green),
    .gain    (green_gain),
    .gain_en (gain_enable[1]),
    .offset  (green_offset),
    .res     (result.out_green)
  );

  pbu_channel u_red (
    .clk     (clk),
    .op      (in_req.op),
    .a       (in_req.top_red),
    .b       (in_req.base_red),
    .gain    (red_gain),
    .gain_en (gain_enable[2]),
    .offset  (red_offset),
    .res     (result.out_red)
  );

`ifndef SYNTHESIS
  a_done_has_request: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 3))
    else $error("done without a matching request");

  a_request_gives_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##3 done)
    else $error("request did not produce a result");

  a_subtract_zero_top: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req.op == OP_SUBTRACT && req.top_blue == 8'd0)
      |-> ##3 (result.out_blue == $past(req.base_blue, 3)))
    else $error("subtract of zero changed the base blue value");

  a_multiply_full_top: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req.op == OP_MULTIPLY && req.top_red == 8'd255)
      |-> ##3 (result.out_red == $past(req.base_red, 3)))
    else $error("multiply by full scale changed the base red value");
`endif

endmodule
